/* rtl/core/line_pixel_stepper_macros.svh */
// Assertion macros shared by the line pixel stepper RTL.
`ifndef LINE_PIXEL_STEPPER_MACROS_SVH
`define LINE_PIXEL_STEPPER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line_pixel_stepper: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line_pixel_stepper: next-cycle check failed");

`endif

/* rtl/core/lps_pkg.sv */
// Types and constants of the line pixel stepper.
package lps_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } lps_dir_t;

  typedef struct packed {
    logic                  func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] color;
  } lps_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
  } lps_out_t;

  typedef struct packed {
    logic load;
    logic advance;
  } lps_axis_ctl_t;

endpackage

/* rtl/core/lps_axis.sv */
// One axis of the line stepper: direction, delta, error accumulator and coordinate.
`include "line_pixel_stepper_macros.svh"

module lps_axis (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lps_pkg::lps_axis_ctl_t        ctl,
  input  logic [lps_pkg::COORD_BITS-1:0] coord_start,
  input  logic [lps_pkg::COORD_BITS-1:0] coord_end,
  input  logic [lps_pkg::COORD_BITS-1:0] span,
  output logic [lps_pkg::COORD_BITS-1:0] mag_load,
  output logic [lps_pkg::COORD_BITS-1:0] cur
);

  logic [lps_pkg::COORD_BITS-1:0] cur_r, cur_nxt;
  logic [lps_pkg::COORD_BITS-1:0] mag_r, mag_nxt;
  logic [lps_pkg::ERR_BITS-1:0]   err_r, err_nxt;
  lps_pkg::lps_dir_t              dir_r, dir_nxt;
  lps_pkg::lps_dir_t              dir_load;
  logic [lps_pkg::ERR_BITS-1:0]   err_sum;
  logic [lps_pkg::COORD_BITS-1:0] cur_moved;

  // Direction and magnitude of a new line along this axis.
  always_comb begin
    if (coord_end > coord_start) begin
      dir_load = lps_pkg::DIR_POS;
      mag_load = coord_end - coord_start;
    end else if (coord_end == coord_start) begin
      dir_load = lps_pkg::DIR_NONE;
      mag_load = '0;
    end else begin
      dir_load = lps_pkg::DIR_NEG;
      mag_load = coord_start - coord_end;
    end
  end

  always_comb begin
    case (dir_r)
      lps_pkg::DIR_POS: cur_moved = cur_r + 1'b1;
      lps_pkg::DIR_NEG: cur_moved = cur_r - 1'b1;
      default:          cur_moved = cur_r;
    endcase
  end

  assign err_sum = err_r + {1'b0, mag_r};

  always_comb begin
    cur_nxt = cur_r;
    mag_nxt = mag_r;
    err_nxt = err_r;
    dir_nxt = dir_r;
    if (ctl.load) begin
      cur_nxt = coord_start;
      mag_nxt = mag_load;
      err_nxt = '0;
      dir_nxt = dir_load;
    end else if (ctl.advance) begin
      // Take a step once the error passes the span.
      if (err_sum > {1'b0, span}) begin
        err_nxt = err_sum - {1'b0, span};
        cur_nxt = cur_moved;
      end else begin
        err_nxt = err_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      mag_r <= '0;
      err_r <= '0;
      dir_r <= lps_pkg::DIR_NONE;
    end else begin
      cur_r <= cur_nxt;
      mag_r <= mag_nxt;
      err_r <= err_nxt;
      dir_r <= dir_nxt;
    end
  end

  assign cur = cur_r;

  `LPS_ASSERT_IMPL(a_err_in_span, 1'b1, err_r <= {1'b0, span})
  `LPS_ASSERT_IMPL(a_mag_in_span, !ctl.load, mag_r <= span)
  `LPS_ASSERT_IMPL(a_dir_matches_mag, 1'b1, (dir_r == lps_pkg::DIR_NONE) == (mag_r == '0))

endmodule

/* rtl/core/line_pixel_stepper.sv */
// Line pixel stepper top level: line setup, pixel count and the result register.
//
// Usage: one valid/ready input channel carries lps_in_t beats. A beat with
// func = start loads both endpoints and the color and produces no result; a
// beat with func = step emits the current pixel of the line on the out_
// channel as one lps_out_t beat, with last set on the final pixel. A line
// from (x0,y0) to (x1,y1) gives max(|dx|,|dy|) + 1 pixels. A step beat while
// no line is armed is consumed and produces nothing. A start beat drops any
// line in progress.
// A step beat's pixel is registered into out_data as the beat is accepted.
// Throughput: one beat per cycle while out_ready stays high; the error update
// of both axes is one add, one compare and one subtract between registers.
// The output register frees in_ready whenever it is empty or being drained,
// so the block keeps pace as long as the receiver takes a pixel every cycle;
// while the receiver stalls with a pixel held, in_ready is low.
// Reset (rst_n low, synchronous) leaves the block idle with no line armed
// and out_valid low.
`include "line_pixel_stepper_macros.svh"

module line_pixel_stepper (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lps_pkg::lps_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lps_pkg::lps_out_t out_data
);

  logic                           in_fire;
  logic                           is_start;
  logic                           is_step;
  lps_pkg::lps_axis_ctl_t         axis_ctl;
  logic [lps_pkg::COORD_BITS-1:0] mag_x_load, mag_y_load;
  logic [lps_pkg::COORD_BITS-1:0] cur_x, cur_y;
  logic [lps_pkg::COORD_BITS-1:0] span_r, span_nxt, span_load;
  logic [lps_pkg::ERR_BITS-1:0]   pixels_left_r, pixels_left_nxt;
  logic [lps_pkg::COLOR_BITS-1:0] line_color_r, line_color_nxt;
  logic                           busy_r, busy_nxt;
  logic                           last_px;
  logic                           out_valid_r, out_valid_nxt;
  lps_pkg::lps_out_t              out_data_r, out_data_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_start = in_fire && (in_data.func == lps_pkg::FUNC_START);
  assign is_step  = in_fire && (in_data.func == lps_pkg::FUNC_STEP) && busy_r;

  assign axis_ctl.load    = is_start;
  assign axis_ctl.advance = is_step;

  lps_axis u_axis_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (axis_ctl),
    .coord_start (in_data.x_start),
    .coord_end   (in_data.x_end),
    .span        (span_r),
    .mag_load    (mag_x_load),
    .cur         (cur_x)
  );

  lps_axis u_axis_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (axis_ctl),
    .coord_start (in_data.y_start),
    .coord_end   (in_data.y_end),
    .span        (span_r),
    .mag_load    (mag_y_load),
    .cur         (cur_y)
  );

  assign span_load = (mag_x_load > mag_y_load) ? mag_x_load : mag_y_load;
  assign last_px   = pixels_left_r <= lps_pkg::ERR_BITS'(1);

  always_comb begin
    span_nxt        = span_r;
    pixels_left_nxt = pixels_left_r;
    line_color_nxt  = line_color_r;
    busy_nxt        = busy_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (is_start) begin
      span_nxt        = span_load;
      pixels_left_nxt = {1'b0, span_load} + 1'b1;
      line_color_nxt  = in_data.color;
      busy_nxt        = 1'b1;
    end else if (is_step) begin
      out_data_nxt.px          = cur_x;
      out_data_nxt.py          = cur_y;
      out_data_nxt.pixel_color = line_color_r;
      out_data_nxt.last        = last_px;
      out_valid_nxt            = 1'b1;
      // Drop the line after its final pixel.
      if (last_px) begin
        pixels_left_nxt = '0;
        busy_nxt        = 1'b0;
      end else begin
        pixels_left_nxt = pixels_left_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r        <= '0;
      pixels_left_r <= '0;
      line_color_r  <= '0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      span_r        <= span_nxt;
      pixels_left_r <= pixels_left_nxt;
      line_color_r  <= line_color_nxt;
      busy_r        <= busy_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LPS_ASSERT_IMPL(a_busy_has_pixels, busy_r, pixels_left_r != '0)
  `LPS_ASSERT_NEXT(a_last_ends_line, is_step && last_px, !busy_r && out_data_r.last)
  `LPS_ASSERT_NEXT(a_idle_step_silent, in_fire && (in_data.func == lps_pkg::FUNC_STEP) && !busy_r,
                   !out_valid_r)

endmodule

/* tb/sv/lps_line_check_pkg.sv */
// Line tracking scoreboard for the line pixel stepper testbench.
package lps_line_check_pkg;
  import lps_pkg::*;

  class line_tracker;
    lps_out_t              expected_pixels[$];
    logic [COORD_BITS-1:0] cur_x = '0;
    logic [COORD_BITS-1:0] cur_y = '0;
    logic [COORD_BITS-1:0] abs_dx = '0;
    logic [COORD_BITS-1:0] abs_dy = '0;
    logic [COORD_BITS-1:0] span = '0;
    logic [ERR_BITS-1:0]   err_x = '0;
    logic [ERR_BITS-1:0]   err_y = '0;
    logic [ERR_BITS-1:0]   pixels_left = '0;
    lps_dir_t              dir_x = DIR_NONE;
    lps_dir_t              dir_y = DIR_NONE;
    logic [COLOR_BITS-1:0] line_color = '0;
    bit                    busy = 1'b0;
    int unsigned           mismatches = 0;
    int unsigned           pixels_checked = 0;

    function void axis_load(input logic [COORD_BITS-1:0] a, input logic [COORD_BITS-1:0] b,
                            output lps_dir_t dir, output logic [COORD_BITS-1:0] mag);
      if (b > a) begin
        dir = DIR_POS;
        mag = b - a;
      end else if (b == a) begin
        dir = DIR_NONE;
        mag = '0;
      end else begin
        dir = DIR_NEG;
        mag = a - b;
      end
    endfunction

    function void axis_step(inout logic [ERR_BITS-1:0] err, input logic [COORD_BITS-1:0] mag,
                            inout logic [COORD_BITS-1:0] c, input lps_dir_t dir);
      logic [ERR_BITS-1:0] e;
      e = err + {1'b0, mag};
      // move only once the error strictly passes the span
      if (e > {1'b0, span}) begin
        e = e - {1'b0, span};
        case (dir)
          DIR_POS: c = c + 1'b1;
          DIR_NEG: c = c - 1'b1;
          default: ;
        endcase
      end
      err = e;
    endfunction

    function void note_beat(input lps_in_t beat);
      lps_out_t pix;
      if (beat.func == FUNC_START) begin
        axis_load(beat.x_start, beat.x_end, dir_x, abs_dx);
        axis_load(beat.y_start, beat.y_end, dir_y, abs_dy);
        span        = (abs_dx > abs_dy) ? abs_dx : abs_dy;
        err_x       = '0;
        err_y       = '0;
        cur_x       = beat.x_start;
        cur_y       = beat.y_start;
        pixels_left = {1'b0, span} + 1'b1;
        line_color  = beat.color;
        busy        = 1'b1;
      end else if (busy) begin
        pix.px          = cur_x;
        pix.py          = cur_y;
        pix.pixel_color = line_color;
        pix.last        = (pixels_left <= ERR_BITS'(1));
        expected_pixels.push_back(pix);
        axis_step(err_x, abs_dx, cur_x, dir_x);
        axis_step(err_y, abs_dy, cur_y, dir_y);
        if (pixels_left <= ERR_BITS'(1)) begin
          pixels_left = '0;
          busy        = 1'b0;
        end else begin
          pixels_left = pixels_left - 1'b1;
        end
      end
    endfunction

    function void check_pixel(input lps_out_t got);
      lps_out_t want;
      if (expected_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected pixel (%0d,%0d) color %h last %b", got.px, got.py,
                   got.pixel_color, got.last);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (got.px !== want.px || got.py !== want.py || got.pixel_color !== want.pixel_color ||
          got.last !== want.last) begin
        if (mismatches < 10)
          $display({"pixel mismatch: expected (%0d,%0d) color %h last %b, ",
                    "got (%0d,%0d) color %h last %b"},
                   want.px, want.py, want.pixel_color, want.last,
                   got.px, got.py, got.pixel_color, got.last);
        mismatches++;
      end
    endfunction

    function int unsigned finish_check();
      if (expected_pixels.size() != 0) begin
        $display("%0d expected pixels never arrived", expected_pixels.size());
        mismatches++;
      end
      return mismatches;
    endfunction
  endclass

endpackage

/* tb/sv/tb_line_pixel_stepper.sv */
// Top-level testbench of the line pixel stepper: stimulus, pixel sink and checking.
module tb_line_pixel_stepper;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;
  import lps_line_check_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lps_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  lps_out_t out_data;

  line_tracker tracker = new;

  line_pixel_stepper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_pixel(out_data);
      if (in_valid && in_ready) tracker.note_beat(in_data);
    end
  end

  // pixel sink: mostly short stalls, a few long ones, and long stall-free runs
  initial begin
    int unsigned r;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(99);
      out_ready <= 1'b1;
      repeat (r < 15 ? $urandom_range(100, 300) : $urandom_range(1, 6)) @(posedge clk);
      r = $urandom_range(99);
      out_ready <= 1'b0;
      repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 50)) @(posedge clk);
    end
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d pixels still expected", tracker.expected_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lps_in_t random_beat(input logic func);
    logic [63:0] bits;
    lps_in_t     beat;
    bits      = {$urandom, $urandom};
    beat      = bits[$bits(lps_in_t)-1:0];
    beat.func = func;
    return beat;
  endfunction

  function automatic lps_in_t line_start(input int xs, input int ys, input int xe, input int ye,
                                         input logic [COLOR_BITS-1:0] color);
    lps_in_t beat;
    beat.func    = FUNC_START;
    beat.x_start = COORD_BITS'(xs);
    beat.y_start = COORD_BITS'(ys);
    beat.x_end   = COORD_BITS'(xe);
    beat.y_end   = COORD_BITS'(ye);
    beat.color   = color;
    return beat;
  endfunction

  // short lines near a random start point; wide ones have random endpoints anywhere in the field
  function automatic lps_in_t random_line(input bit wide);
    lps_in_t beat;
    int      xs;
    int      ys;
    int      dx;
    int      dy;
    beat = random_beat(FUNC_START);
    if (wide) return beat;
    if ($urandom_range(9) == 0) beat.x_start = COORD_BITS'($urandom_range(1) ? COORD_MAX : 0);
    if ($urandom_range(9) == 0) beat.y_start = COORD_BITS'($urandom_range(1) ? COORD_MAX : 0);
    xs = beat.x_start;
    ys = beat.y_start;
    dx = int'($urandom_range(40)) - 20;
    dy = int'($urandom_range(40)) - 20;
    if ($urandom_range(19) == 0) begin
      dx = 0;
      dy = 0;
    end
    beat.x_end = COORD_BITS'((xs + dx < 0 || xs + dx > COORD_MAX) ? xs - dx : xs + dx);
    beat.y_end = COORD_BITS'((ys + dy < 0 || ys + dy > COORD_MAX) ? ys - dy : ys + dy);
    return beat;
  endfunction

  function automatic int unsigned line_pixels(input lps_in_t beat);
    int adx;
    int ady;
    adx = int'(beat.x_end) - int'(beat.x_start);
    ady = int'(beat.y_end) - int'(beat.y_start);
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    return ((adx > ady) ? adx : ady) + 1;
  endfunction

  // hold the beat until accepted; keep valid high across back-to-back beats
  task automatic send_beat(input lps_in_t beat, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic trace_line(input lps_in_t start_beat, input int unsigned steps, input bit quiet);
    send_beat(start_beat, pick_gap(quiet));
    for (int unsigned i = 0; i < steps; i++)
      send_beat(random_beat(FUNC_STEP), pick_gap(quiet));
  endtask

  task automatic wait_line_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned counted;
    int unsigned next_drain;
    int unsigned lines;
    int unsigned cut;
    int unsigned longest;
    int unsigned kind;
    int unsigned len;
    int unsigned steps;
    int unsigned errors;
    bit          quiet;
    lps_in_t     beat;

    counted    = 0;
    next_drain = 300;
    lines      = 0;
    cut        = 0;
    longest    = 0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step with no line armed
    send_beat(random_beat(FUNC_STEP), 1);
    // equal endpoints: one pixel, flagged last
    trace_line(line_start(0, 0, 0, 0, 16'h0000), 1, 1'b0);
    // far corners, dropped part way by the next start
    trace_line(line_start(COORD_MAX, COORD_MAX, 0, 0, 16'hFFFF), 3, 1'b1);
    trace_line(line_start(0, COORD_MAX, COORD_MAX, 0, 16'hA5A5), 2, 1'b0);
    // shallow line with both axes stepping, then one step past its end
    trace_line(line_start(5, 5, 8, 3, 16'h1234), 5, 1'b0);
    trace_line(line_start(600, 10, 600, 12, 16'h5AC3), 3, 1'b1);
    trace_line(line_start(COORD_MAX, 0, COORD_MAX - 3, 0, 16'h07E0), 5, 1'b0);
    wait_line_drained();

    while (counted < 1450) begin
      kind  = $urandom_range(99);
      quiet = ($urandom_range(99) < 20);
      beat  = random_line(kind == 0);
      len   = line_pixels(beat);
      if (kind >= 3 && kind < 13) steps = $urandom_range(0, len - 1);
      else if (kind >= 13 && kind < 23) steps = len + $urandom_range(1, 3);
      else steps = len;
      trace_line(beat, steps, quiet);
      counted += 1 + ((steps < len) ? steps : len);
      lines++;
      if (steps < len) cut++;
      else if (len > longest) longest = len;
      if (counted >= next_drain) begin
        wait_line_drained();
        next_drain += $urandom_range(250, 400);
      end
    end

    in_valid <= 1'b0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    errors = tracker.finish_check();
    $display("Ran %0d random lines (%0d dropped by a restart), longest full line %0d pixels",
             lines, cut, longest);
    $display("Checked %0d pixels in total, %0d mismatches", tracker.pixels_checked, errors);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lps_pkg.sv
rtl/core/lps_axis.sv
rtl/core/line_pixel_stepper.sv
tb/sv/lps_line_check_pkg.sv
tb/sv/tb_line_pixel_stepper.sv
